// File: rtl/sgof_pkg.sv
// ----------------------------------------------------------------------------
// sgof_pkg: shared types and constants of the outlier filter
// Widths, register codes, reset values and the effective-register rules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgof_pkg;

   localparam int MAX_POINTS = 32;
   localparam int IDX_W      = 5;
   localparam int CNT_W      = 6;
   localparam int SAMPLE_W   = 16;
   localparam int Q_W        = 24;
   localparam int SUM_W      = 22;
   localparam int SQ_W       = 38;
   localparam int MB_W       = 22;
   localparam int PROD_W     = 60;
   localparam int DIVN_W     = 57;
   localparam int DIVD_W     = 12;
   localparam int SQRT_W     = 48;
   localparam int ROOT_W     = 24;
   localparam int UC_W       = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic OPC_SAMPLE  = 1'b0;
   localparam logic OPC_RESTART = 1'b1;

   localparam logic [2:0] CSR_WINDOW_LEN     = 3'd0;
   localparam logic [2:0] CSR_BAD_LIMIT      = 3'd1;
   localparam logic [2:0] CSR_GATE_FACTOR    = 3'd2;
   localparam logic [2:0] CSR_CURRENT_WEIGHT = 3'd3;
   localparam logic [2:0] CSR_SD_INTERVAL    = 3'd4;
   localparam logic [2:0] CSR_MIN_DEVIATION  = 3'd5;
   localparam logic [2:0] CSR_INITIAL_VALUE  = 3'd6;
   localparam logic [2:0] CSR_INITIAL_DEV    = 3'd7;

   localparam logic [5:0]  RST_WINDOW_LEN  = 6'd10;
   localparam logic [5:0]  RST_BAD_LIMIT   = 6'd10;
   localparam logic [7:0]  RST_GATE_FACTOR = 8'd32;
   localparam logic [6:0]  RST_WEIGHT      = 7'd50;
   localparam logic [7:0]  RST_SD_INTERVAL = 8'd5;
   localparam logic [23:0] RST_MIN_DEV     = 24'd128;
   localparam logic [15:0] RST_INIT_VALUE  = 16'd0;
   localparam logic [23:0] RST_INIT_DEV    = 24'd1280;
   localparam logic [23:0] FALLBACK_DEV    = 24'd1280;

   typedef enum logic [0:0] {
      DS_DIV,
      DS_SQRT
   } ds_op_type;

   typedef struct packed {
      logic      start;
      ds_op_type op;
   } ds_ctrl_type;

   function automatic logic [5:0] eff_window(input logic [5:0] v);
      return (v >= 6'd1 && v <= 6'(MAX_POINTS)) ? v : RST_WINDOW_LEN;
   endfunction

   function automatic logic [5:0] eff_badlim(input logic [5:0] v);
      return (v >= 6'd1 && v <= 6'(MAX_POINTS)) ? v : RST_BAD_LIMIT;
   endfunction

   function automatic logic [7:0] eff_gate(input logic [7:0] v);
      return (v != 8'd0) ? v : RST_GATE_FACTOR;
   endfunction

   function automatic logic [6:0] eff_weight(input logic [6:0] v);
      return (v >= 7'd1 && v <= 7'd100) ? v : RST_WEIGHT;
   endfunction

   function automatic logic [7:0] eff_interval(input logic [7:0] v);
      return (v != 8'd0) ? v : RST_SD_INTERVAL;
   endfunction

   function automatic logic [23:0] eff_min(input logic [23:0] v);
      return (v != 24'd0) ? v : RST_MIN_DEV;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sgof_if.sv
// ----------------------------------------------------------------------------
// sgof_if: valid/ready channels of the outlier filter
// Request channel carries opcode and sample, response channel the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgof_req_if
   import sgof_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, opcode, sample, input ready);
   modport sink (input valid, opcode, sample, output ready);
endinterface

interface sgof_rsp_if
   import sgof_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic signed [Q_W-1:0] filtered_value;
   logic signed [Q_W-1:0] average;
   logic        [Q_W-1:0] deviation;

   modport source (output valid, accepted, filtered_value, average, deviation,
                   input ready);
   modport sink (input valid, accepted, filtered_value, average, deviation,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/sigma_gated_outlier_filter.sv
// ----------------------------------------------------------------------------
// sigma_gated_outlier_filter: sigma-gated moving average of signed samples
// Sequencer, sample stores, shared multiplier and the register port.
// ----------------------------------------------------------------------------
// The request channel takes one word at a time: a restart opcode or a signed
// sample. Every request word yields exactly one response word holding the
// accepted flag, the blended value, the windowed average and the deviation.
// The block is ready only while its sequencer is idle, and it may take the
// next request while the previous response still waits at the output.
// A restart goes straight to the finish state; a rejected sample first
// passes the gate multiply and compare states. An accepted sample, or a
// reject that swaps the bad set in, walks the window through the store,
// then, unless only one good sample is held, runs the shared 57-step
// divider for the average and, for a window of more than one sample, again
// for the blend, and on a deviation update a third time followed by the
// 24-step square root.
// Reset loads the register defaults and the restart state; the sample
// stores hold no reset value beyond the first good entry, which takes the
// default initial value. A stalled receiver simply holds the response
// register; a finished word waits in the sequencer until it can be loaded.
// The register port is APB-style, always ready, one register per word.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_gated_outlier_filter
   import sgof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   sgof_req_if.sink                   req,
   sgof_rsp_if.source                 rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GATE_MUL,
      ST_GATE_CMP,
      ST_SUM,
      ST_AVG_DIV,
      ST_AVG_WAIT,
      ST_BL_WM,
      ST_BL_A,
      ST_BL_B,
      ST_BL_DIV,
      ST_BL_WAIT,
      ST_CNT,
      ST_DV_P1,
      ST_DV_P2,
      ST_DV_NN,
      ST_DV_DIV,
      ST_DV_WAIT,
      ST_DV_SQRT,
      ST_DV_SQWAIT,
      ST_FINISH
   } state_type;

   // Configuration registers, raw as written.
   logic [5:0]  win_cfg_ff;
   logic [5:0]  blim_cfg_ff;
   logic [7:0]  gate_cfg_ff;
   logic [6:0]  wgt_cfg_ff;
   logic [7:0]  intv_cfg_ff;
   logic [23:0] mindev_cfg_ff;
   logic [15:0] initv_cfg_ff;
   logic [23:0] initdev_cfg_ff;

   // Effective register values.
   logic [5:0]  win_e;
   logic [5:0]  blim_e;
   logic [7:0]  gate_e;
   logic [6:0]  wgt_e;
   logic [7:0]  intv_e;
   logic [23:0] min_e;

   // Filter state.
   state_type             state_ff;
   logic [CNT_W-1:0]      gc_ff;
   logic [CNT_W-1:0]      bc_ff;
   logic [UC_W-1:0]       uc_ff;
   logic [IDX_W-1:0]      base_ff;
   logic                  gsel_ff;
   logic signed [Q_W-1:0] avg_ff;
   logic signed [Q_W-1:0] out_ff;
   logic [Q_W-1:0]        dev_ff;

   // Per-word working registers.
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       acc_ff;
   logic [CNT_W-1:0]           iss_ff;
   logic                       rdv_ff;
   logic                       sqv_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SQ_W-1:0]     sumsq_ff;
   logic signed [SAMPLE_W-1:0] last_ff;
   logic signed [PROD_W-1:0]   tmp_ff;
   logic                       neg_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff;
   logic signed [Q_W-1:0] rsp_out_ff;
   logic signed [Q_W-1:0] rsp_avg_ff;
   logic [Q_W-1:0]        rsp_dev_ff;
   logic                  rsp_load;

   // Sample memory: two banks of MAX_POINTS, good bank picked by gsel_ff.
   logic [SAMPLE_W-1:0] mem [0:2*MAX_POINTS-1];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic                 mem_we;
   logic [IDX_W:0]       mem_waddr;
   logic [SAMPLE_W-1:0]  mem_wdata;
   logic [IDX_W:0]       raddr;

   // Shared multiplier.
   logic signed [SQ_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   // Divider and square root.
   ds_ctrl_type       ds_ctrl;
   logic [DIVN_W-1:0] ds_dividend;
   logic [DIVD_W-1:0] ds_divisor;
   logic              ds_done;
   logic [DIVN_W-1:0] ds_quot;
   logic [ROOT_W-1:0] ds_root;

   // Derived values.
   logic [CNT_W-1:0]       n_w;
   logic [IDX_W-1:0]       m_w;
   logic [CNT_W-1:0]       first_w;
   logic [DIVD_W-1:0]      m100_w;
   logic signed [29:0]     diff_w;
   logic [29:0]            adiff_w;
   logic                   pass_w;
   logic [CNT_W-1:0]       bcn_w;
   logic signed [29:0]     avnum_w;
   logic [29:0]            avmag_w;
   logic signed [39:0]     blsum_w;
   logic signed [47:0]     blnum_w;
   logic [47:0]            blmag_w;
   logic [UC_W:0]          ucn_w;
   logic [Q_W-1:0]         q24_w;
   logic [Q_W-1:0]         init_dev_w;
   logic signed [SUM_W-1:0] last_ext_w;
   logic                   csr_wr;

   assign win_e  = eff_window(win_cfg_ff);
   assign blim_e = eff_badlim(blim_cfg_ff);
   assign gate_e = eff_gate(gate_cfg_ff);
   assign wgt_e  = eff_weight(wgt_cfg_ff);
   assign intv_e = eff_interval(intv_cfg_ff);
   assign min_e  = eff_min(mindev_cfg_ff);

   assign n_w     = (gc_ff < win_e) ? gc_ff : win_e;
   assign m_w     = IDX_W'(n_w - 1'b1);
   assign first_w = gc_ff - n_w;
   assign m100_w  = (DIVD_W'(m_w) << 6) + (DIVD_W'(m_w) << 5) + (DIVD_W'(m_w) << 2);

   // Gate: |x*4096 - avg*16| against gate*dev, the product sitting in prod_ff.
   assign diff_w  = {{2{x_ff[SAMPLE_W-1]}}, x_ff, 12'b0} - {{2{avg_ff[Q_W-1]}}, avg_ff, 4'b0};
   assign adiff_w = diff_w[29] ? 30'(-diff_w) : 30'(diff_w);
   assign pass_w  = {3'b0, adiff_w} <= prod_ff[32:0];
   assign bcn_w   = bc_ff + 1'b1;

   assign avnum_w    = {sum_ff, 8'b0};
   assign avmag_w    = avnum_w[29] ? 30'(-avnum_w) : 30'(avnum_w);
   assign last_ext_w = SUM_W'(last_ff);
   assign blsum_w    = tmp_ff[39:0] + prod_ff[39:0];
   assign blnum_w    = {blsum_w, 8'b0};
   assign blmag_w    = blnum_w[47] ? 48'(-blnum_w) : 48'(blnum_w);
   assign ucn_w      = {1'b0, uc_ff} + 1'b1;
   assign q24_w      = ds_quot[Q_W-1:0];
   assign init_dev_w = (initdev_cfg_ff >= min_e) ? initdev_cfg_ff : FALLBACK_DEV;

   // ---------------------------------------------------------------- memory
   assign raddr = {gsel_ff, IDX_W'(base_ff + first_w[IDX_W-1:0] + iss_ff[IDX_W-1:0])};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {gsel_ff, {IDX_W{1'b0}}};
      mem_wdata = x_ff;
      if (reset) begin
         // Reset leaves the default initial value as the only good sample.
         mem_we    = 1'b1;
         mem_waddr = '0;
         mem_wdata = RST_INIT_VALUE;
      end else if (state_ff == ST_IDLE && req.valid && req.opcode == OPC_RESTART) begin
         mem_we    = 1'b1;
         mem_wdata = initv_cfg_ff;
      end else if (state_ff == ST_GATE_CMP) begin
         mem_we = 1'b1;
         if (pass_w) begin
            // Appending and shifting a full window both land at base + count.
            mem_waddr = {gsel_ff, IDX_W'(base_ff + gc_ff[IDX_W-1:0])};
         end else begin
            mem_waddr = {~gsel_ff, bc_ff[IDX_W-1:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // ------------------------------------------------------------ multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_GATE_MUL: begin
            mul_a = SQ_W'(dev_ff);
            mul_b = MB_W'(gate_e);
         end
         ST_SUM: begin
            mul_a = SQ_W'(rdata_ff);
            mul_b = MB_W'(rdata_ff);
         end
         ST_BL_WM: begin
            mul_a = SQ_W'(wgt_e);
            mul_b = MB_W'(m_w);
         end
         ST_BL_A: begin
            mul_a = SQ_W'(last_ff);
            mul_b = prod_ff[MB_W-1:0];
         end
         ST_BL_B: begin
            mul_a = SQ_W'(7'd100 - wgt_e);
            mul_b = sum_ff - last_ext_w;
         end
         ST_DV_P1: begin
            mul_a = sumsq_ff;
            mul_b = MB_W'(n_w);
         end
         ST_DV_P2: begin
            mul_a = SQ_W'(sum_ff);
            mul_b = sum_ff;
         end
         ST_DV_NN: begin
            mul_a = SQ_W'(n_w);
            mul_b = MB_W'(n_w);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a * mul_b);
   end

   // ------------------------------------------------------- divide and root
   always_comb begin
      ds_ctrl.start = 1'b0;
      ds_ctrl.op    = DS_DIV;
      ds_dividend   = '0;
      ds_divisor    = DIVD_W'(n_w);
      case (state_ff)
         ST_AVG_DIV: begin
            // Round to nearest, ties away from zero, on the magnitude.
            ds_ctrl.start = 1'b1;
            ds_dividend   = DIVN_W'(avmag_w) + DIVN_W'(n_w[CNT_W-1:1]);
            ds_divisor    = DIVD_W'(n_w);
         end
         ST_BL_DIV: begin
            ds_ctrl.start = 1'b1;
            ds_dividend   = DIVN_W'(blmag_w) + DIVN_W'(m100_w[DIVD_W-1:1]);
            ds_divisor    = m100_w;
         end
         ST_DV_DIV: begin
            ds_ctrl.start = 1'b1;
            ds_dividend   = {tmp_ff[40:0], 16'b0};
            ds_divisor    = prod_ff[DIVD_W-1:0];
         end
         ST_DV_SQRT: begin
            ds_ctrl.start = 1'b1;
            ds_ctrl.op    = DS_SQRT;
         end
         default: begin
            ds_ctrl.start = 1'b0;
         end
      endcase
   end

   sgof_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ds_ctrl),
      .dividend (ds_dividend),
      .divisor  (ds_divisor),
      .radicand (ds_quot[SQRT_W-1:0]),
      .done     (ds_done),
      .quotient (ds_quot),
      .root     (ds_root)
   );

   // ------------------------------------------------------------- sequencer
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gc_ff        <= CNT_W'(1);
         bc_ff        <= '0;
         uc_ff        <= '0;
         base_ff      <= '0;
         gsel_ff      <= 1'b0;
         avg_ff       <= '0;
         out_ff       <= '0;
         dev_ff       <= FALLBACK_DEV;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 1'b0;
         iss_ff       <= '0;
         rdv_ff       <= 1'b0;
         sqv_ff       <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_acc_ff   <= acc_ff;
            rsp_out_ff   <= out_ff;
            rsp_avg_ff   <= avg_ff;
            rsp_dev_ff   <= dev_ff;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  if (req.opcode == OPC_RESTART) begin
                     gc_ff    <= CNT_W'(1);
                     bc_ff    <= '0;
                     uc_ff    <= '0;
                     base_ff  <= '0;
                     avg_ff   <= {initv_cfg_ff, 8'b0};
                     out_ff   <= {initv_cfg_ff, 8'b0};
                     dev_ff   <= init_dev_w;
                     acc_ff   <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else begin
                     x_ff     <= req.sample;
                     state_ff <= ST_GATE_MUL;
                  end
               end
            end
            ST_GATE_MUL: begin
               state_ff <= ST_GATE_CMP;
            end
            ST_GATE_CMP: begin
               sum_ff   <= '0;
               sumsq_ff <= '0;
               iss_ff   <= '0;
               rdv_ff   <= 1'b0;
               sqv_ff   <= 1'b0;
               if (pass_w) begin
                  if (gc_ff >= win_e) begin
                     base_ff <= base_ff + 1'b1;
                  end else begin
                     gc_ff <= gc_ff + 1'b1;
                  end
                  bc_ff    <= '0;
                  acc_ff   <= 1'b1;
                  state_ff <= ST_SUM;
               end else if (bcn_w >= blim_e) begin
                  // The bad bank becomes the good set, starting at entry zero.
                  gsel_ff  <= ~gsel_ff;
                  base_ff  <= '0;
                  gc_ff    <= bcn_w;
                  bc_ff    <= '0;
                  uc_ff    <= intv_e;
                  acc_ff   <= 1'b1;
                  state_ff <= ST_SUM;
               end else begin
                  bc_ff    <= bcn_w;
                  acc_ff   <= 1'b0;
                  state_ff <= ST_FINISH;
               end
            end
            ST_SUM: begin
               if (iss_ff < n_w) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               rdv_ff <= (iss_ff < n_w);
               if (rdv_ff) begin
                  sum_ff  <= sum_ff + SUM_W'(rdata_ff);
                  last_ff <= rdata_ff;
               end
               sqv_ff <= rdv_ff;
               if (sqv_ff) begin
                  sumsq_ff <= sumsq_ff + prod_ff[SQ_W-1:0];
               end
               if (iss_ff == n_w && !rdv_ff && !sqv_ff) begin
                  if (gc_ff == CNT_W'(1)) begin
                     avg_ff   <= {last_ff, 8'b0};
                     out_ff   <= {last_ff, 8'b0};
                     state_ff <= ST_CNT;
                  end else begin
                     state_ff <= ST_AVG_DIV;
                  end
               end
            end
            ST_AVG_DIV: begin
               neg_ff   <= avnum_w[29];
               state_ff <= ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
               if (ds_done) begin
                  avg_ff <= neg_ff ? Q_W'(-q24_w) : q24_w;
                  if (n_w == CNT_W'(1)) begin
                     out_ff   <= {last_ff, 8'b0};
                     state_ff <= ST_CNT;
                  end else begin
                     state_ff <= ST_BL_WM;
                  end
               end
            end
            ST_BL_WM: begin
               state_ff <= ST_BL_A;
            end
            ST_BL_A: begin
               state_ff <= ST_BL_B;
            end
            ST_BL_B: begin
               tmp_ff   <= prod_ff;
               state_ff <= ST_BL_DIV;
            end
            ST_BL_DIV: begin
               neg_ff   <= blsum_w[39];
               state_ff <= ST_BL_WAIT;
            end
            ST_BL_WAIT: begin
               if (ds_done) begin
                  out_ff   <= neg_ff ? Q_W'(-q24_w) : q24_w;
                  state_ff <= ST_CNT;
               end
            end
            ST_CNT: begin
               if (ucn_w >= {1'b0, intv_e}) begin
                  uc_ff    <= '0;
                  state_ff <= (gc_ff > CNT_W'(1)) ? ST_DV_P1 : ST_FINISH;
               end else begin
                  uc_ff    <= ucn_w[UC_W-1:0];
                  state_ff <= ST_FINISH;
               end
            end
            ST_DV_P1: begin
               state_ff <= ST_DV_P2;
            end
            ST_DV_P2: begin
               tmp_ff   <= prod_ff;
               state_ff <= ST_DV_NN;
            end
            ST_DV_NN: begin
               // n * sum of squares less the squared sum: n^2 times the variance.
               tmp_ff   <= tmp_ff - prod_ff;
               state_ff <= ST_DV_DIV;
            end
            ST_DV_DIV: begin
               state_ff <= ST_DV_WAIT;
            end
            ST_DV_WAIT: begin
               if (ds_done) begin
                  state_ff <= ST_DV_SQRT;
               end
            end
            ST_DV_SQRT: begin
               state_ff <= ST_DV_SQWAIT;
            end
            ST_DV_SQWAIT: begin
               if (ds_done) begin
                  dev_ff   <= (ds_root < min_e) ? min_e : ds_root;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = rsp_acc_ff;
   assign rsp.filtered_value = rsp_out_ff;
   assign rsp.average        = rsp_avg_ff;
   assign rsp.deviation      = rsp_dev_ff;

   // -------------------------------------------------------- register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff     <= RST_WINDOW_LEN;
         blim_cfg_ff    <= RST_BAD_LIMIT;
         gate_cfg_ff    <= RST_GATE_FACTOR;
         wgt_cfg_ff     <= RST_WEIGHT;
         intv_cfg_ff    <= RST_SD_INTERVAL;
         mindev_cfg_ff  <= RST_MIN_DEV;
         initv_cfg_ff   <= RST_INIT_VALUE;
         initdev_cfg_ff <= RST_INIT_DEV;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            CSR_WINDOW_LEN:     win_cfg_ff     <= csr_pwdata[5:0];
            CSR_BAD_LIMIT:      blim_cfg_ff    <= csr_pwdata[5:0];
            CSR_GATE_FACTOR:    gate_cfg_ff    <= csr_pwdata[7:0];
            CSR_CURRENT_WEIGHT: wgt_cfg_ff     <= csr_pwdata[6:0];
            CSR_SD_INTERVAL:    intv_cfg_ff    <= csr_pwdata[7:0];
            CSR_MIN_DEVIATION:  mindev_cfg_ff  <= csr_pwdata[23:0];
            CSR_INITIAL_VALUE:  initv_cfg_ff   <= csr_pwdata[15:0];
            CSR_INITIAL_DEV:    initdev_cfg_ff <= csr_pwdata[23:0];
            default:            win_cfg_ff     <= win_cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         CSR_WINDOW_LEN:     csr_prdata = CSR_DATA_W'(win_cfg_ff);
         CSR_BAD_LIMIT:      csr_prdata = CSR_DATA_W'(blim_cfg_ff);
         CSR_GATE_FACTOR:    csr_prdata = CSR_DATA_W'(gate_cfg_ff);
         CSR_CURRENT_WEIGHT: csr_prdata = CSR_DATA_W'(wgt_cfg_ff);
         CSR_SD_INTERVAL:    csr_prdata = CSR_DATA_W'(intv_cfg_ff);
         CSR_MIN_DEVIATION:  csr_prdata = CSR_DATA_W'(mindev_cfg_ff);
         CSR_INITIAL_VALUE:  csr_prdata = CSR_DATA_W'(initv_cfg_ff);
         CSR_INITIAL_DEV:    csr_prdata = CSR_DATA_W'(initdev_cfg_ff);
         default:            csr_prdata = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_good_count_range: assert property (@(posedge clock) disable iff (reset)
      (gc_ff != 6'd0) && (gc_ff <= 6'(MAX_POINTS)))
      else $error("good count out of range");

   a_bad_count_range: assert property (@(posedge clock) disable iff (reset)
      bc_ff < 6'(MAX_POINTS))
      else $error("bad count reached the store depth");

   a_deviation_nonzero: assert property (@(posedge clock) disable iff (reset)
      dev_ff != '0)
      else $error("deviation dropped to zero");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (iss_ff <= n_w))
      else $error("window walk read past its window");
`endif

endmodule

`default_nettype wire

// File: rtl/sgof_divsqrt.sv
// ----------------------------------------------------------------------------
// sgof_divsqrt: iterative divider and square root
// Restoring division one quotient bit per cycle, integer root one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgof_divsqrt
   import sgof_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ds_ctrl_type       ctrl,
   input  wire logic [DIVN_W-1:0] dividend,
   input  wire logic [DIVD_W-1:0] divisor,
   input  wire logic [SQRT_W-1:0] radicand,
   output logic                   done,
   output logic [DIVN_W-1:0]      quotient,
   output logic [ROOT_W-1:0]      root
);

   localparam int STEP_W     = $clog2(DIVN_W + 1);
   localparam int SQRT_STEPS = SQRT_W / 2;

   logic              busy_ff;
   logic              done_ff;
   ds_op_type         op_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DIVN_W-1:0] num_ff;
   logic [DIVD_W-1:0] rem_ff;
   logic [DIVD_W-1:0] den_ff;
   logic [SQRT_W-1:0] x_ff;
   logic [SQRT_W-1:0] r_ff;
   logic [SQRT_W-1:0] bit_ff;

   logic [DIVD_W:0]   trial;
   logic              fits;
   logic [DIVD_W-1:0] rem_in;
   logic [SQRT_W-1:0] sq_t;
   logic              sq_ge;
   logic              load;

   assign load   = ctrl.start && !busy_ff;
   assign trial  = {rem_ff, num_ff[DIVN_W-1]};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? DIVD_W'(trial - {1'b0, den_ff}) : trial[DIVD_W-1:0];
   assign sq_t   = r_ff + bit_ff;
   assign sq_ge  = x_ff >= sq_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= (ctrl.op == DS_SQRT) ? STEP_W'(SQRT_STEPS) : STEP_W'(DIVN_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= ctrl.op;
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         x_ff   <= radicand;
         r_ff   <= '0;
         bit_ff <= {2'b01, {(SQRT_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (op_ff == DS_DIV) begin
            num_ff <= {num_ff[DIVN_W-2:0], fits};
            rem_ff <= rem_in;
         end else begin
            if (sq_ge) begin
               x_ff <= x_ff - sq_t;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;
   assign root     = r_ff[ROOT_W-1:0];

endmodule

`default_nettype wire
